>>> hw/rtl/cso_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths for the cell search order comparator.
// No dependencies.
package cso_pkg;

	localparam int COORD_BITS = 8;
	localparam int GEN_BITS   = 4;
	localparam int CFG_BITS   = 8;

	typedef logic signed [1:0] ord_t;

	typedef enum logic [2:0] {
		MODE_LEFT_RIGHT = 3'd0,
		MODE_DIAG       = 3'd1,
		MODE_BACK_DIAG  = 3'd2,
		MODE_KNIGHT     = 3'd3,
		MODE_TOP_DOWN   = 3'd4,
		MODE_CENTER_OUT = 3'd5,
		MODE_MIDDLE_COL = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		REG_ORDER_MODE       = 3'd0,
		REG_PARENT_MODE      = 3'd1,
		REG_GENS_BY_POSITION = 3'd2,
		REG_INVERT_PRIMARY   = 3'd3,
		REG_WIDE_ORDER       = 3'd4,
		REG_MIDDLE_OVERRIDE  = 3'd5,
		REG_LAST_COLUMN      = 3'd6,
		REG_LAST_ROW         = 3'd7
	} reg_idx_t;

	localparam ord_t ORD_BEFORE = 2'sb11;
	localparam ord_t ORD_EQUAL  = 2'sb00;
	localparam ord_t ORD_AFTER  = 2'sb01;

endpackage

>>> hw/rtl/cso_if.sv
`timescale 1ns / 1ps
// Valid/ready channels: cell pair beats in, order beats out.
// Depends on cso_pkg.
interface cso_item_if;
	import cso_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] row_a;
	logic [COORD_BITS-1:0] col_a;
	logic [GEN_BITS-1:0]   gen_a;
	logic [COORD_BITS-1:0] row_b;
	logic [COORD_BITS-1:0] col_b;
	logic [GEN_BITS-1:0]   gen_b;

	modport source (output valid, row_a, col_a, gen_a, row_b, col_b, gen_b, input ready);
	modport sink (input valid, row_a, col_a, gen_a, row_b, col_b, gen_b, output ready);
endinterface

interface cso_result_if;
	import cso_pkg::*;
	logic valid;
	logic ready;
	ord_t order;

	modport source (output valid, order, input ready);
	modport sink (input valid, order, output ready);
endinterface

>>> hw/rtl/cell_search_order_compare_unit.sv
`timescale 1ns / 1ps
// Cell search order comparator: input register, one compare pass, result register.
// Depends on cso_pkg and cso_if.
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------
//  item     | in  | row_a, col_a, gen_a, row_b, col_b, gen_b
//  result   | out | order (-1 before, 0 equal, 1 after)
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle sustained while result.ready holds; a beat passes the input reg, then the result reg.
// Center-out keys use two small squarers per cell ahead of the compare.
// arst_n clears valids and all config registers to zero.
// A stalled result stage holds; the input stage fills and then drops ready.
module cell_search_order_compare_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	cso_item_if.sink                         item,
	cso_result_if.source                     result,
	input  logic                             cfg_we,
	input  cso_pkg::reg_idx_t                cfg_index,
	input  logic [cso_pkg::CFG_BITS-1:0]     cfg_data
);
	import cso_pkg::*;

	localparam int PW = COORD_BITS + 3;
	localparam int QW = 2 * COORD_BITS + 5;

	function automatic logic signed [PW-1:0] ext_p(input logic [COORD_BITS-1:0] v);
		return $signed({{(PW-COORD_BITS){1'b0}}, v});
	endfunction

	function automatic logic signed [PW-1:0] abs_p(input logic signed [PW-1:0] v);
		return v[PW-1] ? -v : v;
	endfunction

	function automatic ord_t cmp_p(input logic signed [PW-1:0] a, input logic signed [PW-1:0] b);
		return (a > b) ? ORD_AFTER : ((a < b) ? ORD_BEFORE : ORD_EQUAL);
	endfunction

	function automatic ord_t cmp_q(input logic signed [QW-1:0] a, input logic signed [QW-1:0] b);
		return (a > b) ? ORD_AFTER : ((a < b) ? ORD_BEFORE : ORD_EQUAL);
	endfunction

	// config registers
	logic [2:0]            order_mode_q;
	logic                  parent_mode_q;
	logic                  gens_by_pos_q;
	logic                  invert_prim_q;
	logic                  wide_order_q;
	logic                  middle_ovr_q;
	logic [COORD_BITS-1:0] last_col_q;
	logic [COORD_BITS-1:0] last_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q  <= '0;
			parent_mode_q <= 1'b0;
			gens_by_pos_q <= 1'b0;
			invert_prim_q <= 1'b0;
			wide_order_q  <= 1'b0;
			middle_ovr_q  <= 1'b0;
			last_col_q    <= '0;
			last_row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORDER_MODE:       order_mode_q  <= cfg_data[2:0];
				REG_PARENT_MODE:      parent_mode_q <= cfg_data[0];
				REG_GENS_BY_POSITION: gens_by_pos_q <= cfg_data[0];
				REG_INVERT_PRIMARY:   invert_prim_q <= cfg_data[0];
				REG_WIDE_ORDER:       wide_order_q  <= cfg_data[0];
				REG_MIDDLE_OVERRIDE:  middle_ovr_q  <= cfg_data[0];
				REG_LAST_COLUMN:      last_col_q    <= cfg_data[COORD_BITS-1:0];
				REG_LAST_ROW:         last_row_q    <= cfg_data[COORD_BITS-1:0];
			endcase
		end
	end

	// handshake
	logic valid_s1, valid_q;
	logic free_out, free_s1;

	assign free_out   = !valid_q || result.ready;
	assign free_s1    = !valid_s1 || free_out;
	assign item.ready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (free_s1)  valid_s1 <= item.valid;
			if (free_out) valid_q  <= valid_s1;
		end
	end

	// stage 1: input register
	logic [COORD_BITS-1:0] row_s1 [2];
	logic [COORD_BITS-1:0] col_s1 [2];
	logic [GEN_BITS-1:0]   gen_s1 [2];

	always_ff @(posedge clk) begin
		if (item.valid && free_s1) begin
			row_s1[0] <= item.row_a;
			col_s1[0] <= item.col_a;
			gen_s1[0] <= item.gen_a;
			row_s1[1] <= item.row_b;
			col_s1[1] <= item.col_b;
			gen_s1[1] <= item.gen_b;
		end
	end

	// key formation
	mode_t                 eff_mode;
	logic [COORD_BITS-1:0] mid_col, mid_row;
	logic                  prim_inv, sec_neg;
	ord_t                  gen_ord;
	logic                  gen_first;
	logic signed [PW-1:0]  pkey [2];
	logic signed [QW-1:0]  qkey [2];

	assign mid_col = COORD_BITS'(({1'b0, last_col_q} + 1'b1) >> 1);
	assign mid_row = COORD_BITS'(({1'b0, last_row_q} + 1'b1) >> 1);

	always_comb begin
		unique case (order_mode_q)
			MODE_DIAG:       eff_mode = MODE_DIAG;
			MODE_BACK_DIAG:  eff_mode = MODE_BACK_DIAG;
			MODE_KNIGHT:     eff_mode = MODE_KNIGHT;
			MODE_TOP_DOWN:   eff_mode = MODE_TOP_DOWN;
			MODE_CENTER_OUT: eff_mode = MODE_CENTER_OUT;
			MODE_MIDDLE_COL: eff_mode = MODE_MIDDLE_COL;
			default:         eff_mode = middle_ovr_q ? MODE_MIDDLE_COL : MODE_LEFT_RIGHT;
		endcase
	end

	always_comb begin
		prim_inv = invert_prim_q;
		sec_neg  = 1'b0;
		unique case (eff_mode)
			MODE_DIAG, MODE_BACK_DIAG: sec_neg = wide_order_q;
			MODE_KNIGHT:               sec_neg = !wide_order_q;
			MODE_CENTER_OUT:           sec_neg = wide_order_q;
			MODE_MIDDLE_COL: begin
				prim_inv = 1'b0;
				sec_neg  = !wide_order_q;
			end
			default:                   sec_neg = 1'b0;
		endcase
	end

	always_comb begin
		logic signed [PW-1:0] c, r, m, d_diag, d_back, d_col, d_row, x, y;
		logic signed [QW-1:0] xw, yw;
		for (int i = 0; i < 2; i++) begin
			c      = ext_p(col_s1[i]);
			r      = ext_p(row_s1[i]);
			m      = ext_p(last_col_q) - c + PW'(1);
			d_diag = c - r;
			d_back = m - r;
			d_col  = c - ext_p(mid_col);
			d_row  = r - ext_p(mid_row);
			x      = ext_p(last_col_q) + PW'(1) - (c <<< 1);
			y      = ext_p(last_row_q) + PW'(1) - (r <<< 1);
			xw     = QW'(x);
			yw     = QW'(y);
			unique case (eff_mode)
				MODE_DIAG: begin
					pkey[i] = c + r;
					qkey[i] = QW'(wide_order_q ? d_diag : abs_p(d_diag));
				end
				MODE_BACK_DIAG: begin
					pkey[i] = m + r;
					qkey[i] = QW'(wide_order_q ? d_back : abs_p(d_back));
				end
				MODE_KNIGHT: begin
					pkey[i] = (c <<< 1) + r;
					qkey[i] = QW'(abs_p(d_diag));
				end
				MODE_TOP_DOWN: begin
					pkey[i] = r;
					qkey[i] = QW'(wide_order_q ? d_col : abs_p(d_col));
				end
				MODE_CENTER_OUT: begin
					pkey[i] = '0;
					qkey[i] = xw * xw + yw * yw;
				end
				MODE_MIDDLE_COL: begin
					pkey[i] = abs_p(d_col);
					qkey[i] = QW'(abs_p(d_row));
				end
				default: begin
					pkey[i] = c;
					qkey[i] = QW'(wide_order_q ? d_row : abs_p(d_row));
				end
			endcase
		end
	end

	always_comb begin
		ord_t g;
		g         = (gen_s1[0] > gen_s1[1]) ? ORD_AFTER :
		            ((gen_s1[0] < gen_s1[1]) ? ORD_BEFORE : ORD_EQUAL);
		gen_ord   = parent_mode_q ? -g : g;
		gen_first = ((row_s1[0] == row_s1[1] && col_s1[0] == col_s1[1]) || !gens_by_pos_q)
		            && (gen_ord != ORD_EQUAL);
	end

	// final decision
	ord_t prim_ord, sec_ord, order_d, order_q;

	always_comb begin
		prim_ord = cmp_p(pkey[0], pkey[1]);
		sec_ord  = cmp_q(qkey[0], qkey[1]);
		priority if (gen_first)
			order_d = gen_ord;
		else if (prim_ord != ORD_EQUAL)
			order_d = prim_inv ? -prim_ord : prim_ord;
		else if (sec_ord != ORD_EQUAL)
			order_d = sec_neg ? -sec_ord : sec_ord;
		else
			order_d = gen_ord;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && free_out) order_q <= order_d;
	end

	assign result.valid = valid_q;
	assign result.order = order_q;

	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.order != 2'sb10)
		else $error("result order holds an illegal code");

	a_gen_decides: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && free_out && gen_first |=> result.order == $past(gen_ord))
		else $error("generation order not taken first");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !free_out |=> valid_s1 && $stable(row_s1[0]) && $stable(col_s1[0]))
		else $error("input stage dropped a beat under stall");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && free_out |=> valid_q)
		else $error("input stage beat lost on the way out");

endmodule
